// ----- sv/rdsc_pkg.sv -----
package rdsc_pkg;

   // Default sizes of the converter.
   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_DIGITS_DEF  = 64;

   // Fixed widths of the transaction fields.
   localparam int VALUE_W = 64;
   localparam int RADIX_W = 7;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   // Accepted range of the base.
   localparam logic [RADIX_W-1:0] RADIX_MIN = 7'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 7'd64;

   // ASCII anchors of the digit alphabet.
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // take a new transaction into the divider
      logic step;        // one shift-subtract step of the divider
      logic pop;         // read the top digit off the stack
      logic emit_digit;  // load the output register with the popped digit
      logic emit_error;  // load the output register with the error result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_bad;      // base of the offered transaction is out of range
      logic step_last;    // current step finishes one division
      logic quo_zero;     // quotient of the finishing division is zero
      logic stack_empty;  // no digits left to pop
      logic out_free;     // output register can take a new result
   } status_type;

   // Digit alphabet: 0-9, A-Z, a-z, '+', '/'.
   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {1'b0, d};
      if (d < 6'd10) begin
         digit_ascii = CHAR_ZERO + dx;
      end else if (d < 6'd36) begin
         digit_ascii = CHAR_UPPER + dx - 7'd10;
      end else if (d < 6'd62) begin
         digit_ascii = CHAR_LOWER + dx - 7'd36;
      end else if (d == 6'd62) begin
         digit_ascii = CHAR_PLUS;
      end else begin
         digit_ascii = CHAR_SLASH;
      end
   endfunction

endpackage

// ----- sv/rdsc_datapath.sv -----
module rdsc_datapath #(
   parameter int VALUE_WIDTH = rdsc_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = rdsc_pkg::MAX_DIGITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rdsc_pkg::VALUE_W-1:0]   req_value,
   input  logic [rdsc_pkg::RADIX_W-1:0]   req_radix,
   input  rdsc_pkg::cmd_type              cmd,
   output rdsc_pkg::status_type           status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rdsc_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                           rsp_last_digit,
   output logic                           rsp_bad_radix
);

   localparam int SW = $clog2(VALUE_WIDTH);
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);
   localparam int DW = rdsc_pkg::DIGIT_W;
   localparam int RW = rdsc_pkg::RADIX_W;

   // Divider registers: the dividend shifts out at the top while quotient bits
   // enter at the bottom.
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [RW-1:0]          radix_ff, radix_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [CW-1:0]          count_ff, count_in;

   // Digit stack and its registered read port.
   logic [DW-1:0]          stack_mem [MAX_DIGITS];
   logic [DW-1:0]          rd_data_ff;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic                   push;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [rdsc_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   // One shift-subtract step.
   logic [RW-1:0]          r_shift;
   logic [RW-1:0]          r_diff;
   logic                   q_bit;
   logic [DW-1:0]          r_new;
   logic [VALUE_WIDTH-1:0] q_new;

   always_comb begin
      r_shift = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      r_diff  = r_shift - radix_ff;
      q_bit   = (r_shift >= radix_ff);
      r_new   = q_bit ? r_diff[DW-1:0] : r_shift[DW-1:0];
      q_new   = {quo_ff[VALUE_WIDTH-2:0], q_bit};
   end

   // Status toward the controller.
   always_comb begin
      status.req_bad     = (req_radix < rdsc_pkg::RADIX_MIN) ||
                           (req_radix > rdsc_pkg::RADIX_MAX);
      status.step_last   = (step_ff == SW'(VALUE_WIDTH - 1));
      status.quo_zero    = (q_new == '0);
      status.stack_empty = (count_ff == '0);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Divider and digit counter next values.
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      step_in  = step_ff;
      count_in = count_ff;
      push     = 1'b0;
      if (cmd.load) begin
         quo_in   = req_value[VALUE_WIDTH-1:0];
         radix_in = req_radix;
         rem_in   = '0;
         step_in  = '0;
         count_in = '0;
      end else if (cmd.step) begin
         quo_in = q_new;
         if (status.step_last) begin
            // Division done: the remainder is the next digit, start afresh.
            rem_in  = '0;
            step_in = '0;
            if (count_ff < CW'(MAX_DIGITS)) begin
               push     = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end else begin
            rem_in  = r_new;
            step_in = step_ff + 1'b1;
         end
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign wr_addr = count_ff[AW-1:0];
   assign rd_addr = AW'(count_ff - 1'b1);

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      if (reset) begin
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[wr_addr] <= r_new;
      end
      if (cmd.pop) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // Output register holds a result until the rsp side takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = rdsc_pkg::digit_ascii(rd_data_ff);
         rsp_last_in  = status.stack_empty;
         rsp_bad_in   = 1'b0;
      end else if (cmd.emit_error) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = '0;
         rsp_last_in  = 1'b1;
         rsp_bad_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;
   assign rsp_bad_radix  = rsp_bad_ff;

`ifndef SYNTHESIS
   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit || cmd.emit_error) |-> status.out_free)
      else $error("result loaded while output register is busy");

   // Digits are only popped while the stack holds some.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !status.stack_empty)
      else $error("pop from an empty digit stack");

   // The digit count never passes the stack depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DIGITS))
      else $error("digit count beyond stack depth");

   // An error result is always the final one of its transaction.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_last_ff && rsp_char_ff == '0))
      else $error("error result not marked final");
`endif

endmodule

// ----- sv/rdsc_ctrl.sv -----
module rdsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rdsc_pkg::status_type status,
   output rdsc_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_READ = 5'b00100,
      ST_LOAD = 5'b01000,
      ST_ERR  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Sequencing: a bad base goes to the error result; otherwise divide until the quotient is zero, then pop and emit.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_bad ? ST_ERR : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.step_last && status.quo_zero) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.pop  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in = status.stack_empty ? ST_IDLE : ST_READ;
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               cmd.emit_error = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/radix_digit_string_converter_core.sv -----
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_value[63:0], req_radix[6:0]
// rsp      out        rsp_valid, rsp_ready, rsp_digit_char[6:0], rsp_last_digit,
//                     rsp_bad_radix
//
// A conversion of D digits runs D divisions in the restoring divider, one quotient
// bit per cycle, then pops each digit off the stack and emits it, most significant first.
// A bad base goes straight to the error result.
// One transaction is worked on at a time. Reset is synchronous and active high;
// the digit stack needs no clearing. A stalled rsp side holds the emission; the
// next request is taken while the final result still waits in the output register.
module radix_digit_string_converter_core #(
   parameter int VALUE_WIDTH = rdsc_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = rdsc_pkg::MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rdsc_pkg::VALUE_W-1:0]  req_value,
   input  logic [rdsc_pkg::RADIX_W-1:0]  req_radix,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdsc_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                          rsp_last_digit,
   output logic                          rsp_bad_radix
);

   rdsc_pkg::cmd_type    cmd;
   rdsc_pkg::status_type status;

   // Controller.
   rdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Divider, digit stack and output register.
   rdsc_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .rsp_bad_radix  (rsp_bad_radix)
   );

endmodule
